/* hdl/lrup_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrup_pkg
// Shared widths, the configuration reset value and controller/datapath handshake types for the
// LRU page replacement core.
// ----------------------------------------------------------------------------
package lrup_pkg;

  localparam int PAGE_W         = 16;
  localparam int STAMP_W        = 32;
  localparam int FAULT_W        = 32;
  localparam int CFG_W          = 3;
  localparam int FRAME_W        = 2;
  localparam int NUM_FRAMES_DEF = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture a new request and clear scan results
    logic rd_en;   // read one frame table entry
    logic cmp_en;  // fold the entry read last cycle into the scan results
    logic commit;  // update the frame table and load the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } sts_t;

endpackage

/* hdl/lru_page_replacement_core.sv */
// A request is scanned over N frames, N being the effective frame count
// (frames_in_use, clipped to 1..NUM_FRAMES). The scan reads the frame table
// RAM one entry per cycle; drain and a commit that waits for a free result
// register follow, and a new request is taken only once back in idle.
// Reset (synchronous, active low) clears frame valid bits, the stamp and
// fault counters and sets frames_in_use to 3; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement over a small frame set: hit lookup, fill of the first
// empty frame, or eviction of the least recently used frame.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
  parameter int NUM_FRAMES = lrup_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lrup_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrup_pkg::PAGE_W-1:0]   in_page,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [lrup_pkg::FRAME_W-1:0]  out_frame,
  output logic                          out_evicted_valid,
  output logic [lrup_pkg::PAGE_W-1:0]   out_evicted_page,
  output logic [lrup_pkg::FAULT_W-1:0]  out_fault_count
);
  import lrup_pkg::*;

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;

  lrup_ctrl #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .last_idx (last_idx),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .cmp_idx  (cmp_idx)
  );

  lrup_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_page           (in_page),
    .cmd               (cmd),
    .rd_idx            (rd_idx),
    .cmp_idx           (cmp_idx),
    .sts               (sts),
    .last_idx          (last_idx),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame         (out_frame),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

endmodule

/* hdl/lrup_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrup_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/lrup_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrup_ctrl
// Sequencer: accepts a request, walks the active frames one read per cycle,
// then commits the replacement decision once the result register is free.
// ----------------------------------------------------------------------------
module lrup_ctrl #(
  parameter int NUM_FRAMES = 4
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_stall,
  input  lrup_pkg::sts_t                                 sts,
  input  logic [(NUM_FRAMES > 1 ? $clog2(NUM_FRAMES) : 1)-1:0] last_idx,
  output lrup_pkg::cmd_t                                 cmd,
  output logic [(NUM_FRAMES > 1 ? $clog2(NUM_FRAMES) : 1)-1:0] rd_idx,
  output logic [(NUM_FRAMES > 1 ? $clog2(NUM_FRAMES) : 1)-1:0] cmp_idx
);
  import lrup_pkg::*;

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign rd_idx   = idx_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    cmp_idx    = idx_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en  = 1'b1;
        // the entry read in the previous cycle is compared now
        cmd.cmp_en = (idx_r != '0);
        cmp_idx    = idx_r - 1'b1;
        if (idx_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd.cmp_en = 1'b1;
        cmp_idx    = idx_r;
        state_nxt  = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

/* hdl/lrup_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrup_datapath
// Frame table (page and last-use stamp in RAM, valid bits in flops), scan
// accumulators for hit, first empty and oldest frame, counters and the
// result register.
// ----------------------------------------------------------------------------
module lrup_datapath #(
  parameter int NUM_FRAMES = 4
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           cfg_we,
  input  logic [lrup_pkg::CFG_W-1:0]                     cfg_wdata,
  input  logic [lrup_pkg::PAGE_W-1:0]                    in_page,
  input  lrup_pkg::cmd_t                                 cmd,
  input  logic [(NUM_FRAMES > 1 ? $clog2(NUM_FRAMES) : 1)-1:0] rd_idx,
  input  logic [(NUM_FRAMES > 1 ? $clog2(NUM_FRAMES) : 1)-1:0] cmp_idx,
  output lrup_pkg::sts_t                                 sts,
  output logic [(NUM_FRAMES > 1 ? $clog2(NUM_FRAMES) : 1)-1:0] last_idx,
  output logic                                           out_valid,
  input  logic                                           out_stall,
  output logic                                           out_hit,
  output logic [lrup_pkg::FRAME_W-1:0]                   out_frame,
  output logic                                           out_evicted_valid,
  output logic [lrup_pkg::PAGE_W-1:0]                    out_evicted_page,
  output logic [lrup_pkg::FAULT_W-1:0]                   out_fault_count
);
  import lrup_pkg::*;

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int ENT_W = PAGE_W + STAMP_W;

  // configuration and counters
  logic [CFG_W-1:0]      cfg_r;
  logic [STAMP_W-1:0]    ref_cnt_r;
  logic [FAULT_W-1:0]    faults_r, faults_nxt;
  logic [NUM_FRAMES-1:0] valid_r;

  // request and scan accumulators
  logic [PAGE_W-1:0]     page_r;
  logic                  found_r;
  logic [IDX_W-1:0]      found_idx_r;
  logic                  empty_r;
  logic [IDX_W-1:0]      empty_idx_r;
  logic [STAMP_W-1:0]    min_stamp_r;
  logic [IDX_W-1:0]      min_idx_r;
  logic [PAGE_W-1:0]     min_page_r;

  // result register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [FRAME_W-1:0]    out_frame_r;
  logic                  out_ev_valid_r;
  logic [PAGE_W-1:0]     out_ev_page_r;
  logic [FAULT_W-1:0]    out_fault_r;

  // frame table port signals
  logic [ENT_W-1:0]      rd_data;
  logic [PAGE_W-1:0]     rd_page;
  logic [STAMP_W-1:0]    rd_stamp;
  logic                  rd_valid;
  logic [CFG_W-1:0]      cfg_m1;

  // commit decision
  logic [IDX_W-1:0]      slot;
  logic                  ev_valid;
  logic [PAGE_W-1:0]     ev_page;

  lrup_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (slot),
    .wdata ({page_r, ref_cnt_r}),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  assign rd_page  = rd_data[ENT_W-1:STAMP_W];
  assign rd_stamp = rd_data[STAMP_W-1:0];
  assign rd_valid = valid_r[cmp_idx];

  // effective frame count: zero acts as one, clipped at NUM_FRAMES
  assign cfg_m1 = cfg_r - 1'b1;
  always_comb begin
    if (cfg_r == '0) begin
      last_idx = '0;
    end else if ({29'd0, cfg_r} > 32'(NUM_FRAMES)) begin
      last_idx = IDX_W'(NUM_FRAMES - 1);
    end else begin
      last_idx = IDX_W'(cfg_m1);
    end
  end

  // hit, then first empty frame, else the oldest stamp
  always_comb begin
    ev_valid = 1'b0;
    ev_page  = '0;
    if (found_r) begin
      slot = found_idx_r;
    end else if (empty_r) begin
      slot = empty_idx_r;
    end else begin
      slot     = min_idx_r;
      ev_valid = 1'b1;
      ev_page  = min_page_r;
    end
  end

  assign faults_nxt = (!found_r && (faults_r != '1)) ? faults_r + 1'b1 : faults_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // frame valid bits and saturating counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      ref_cnt_r <= '0;
      faults_r  <= '0;
    end else if (cmd.commit) begin
      valid_r[slot] <= 1'b1;
      faults_r      <= faults_nxt;
      if (ref_cnt_r != '1) begin
        ref_cnt_r <= ref_cnt_r + 1'b1;
      end
    end
  end

  // scan accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      empty_r <= 1'b0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      empty_r <= 1'b0;
    end else if (cmd.cmp_en) begin
      if (rd_valid && (rd_page == page_r) && !found_r) begin
        found_r <= 1'b1;
      end
      if (!rd_valid && !empty_r) begin
        empty_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_page;
    end
    if (cmd.cmp_en) begin
      if (rd_valid && (rd_page == page_r) && !found_r) begin
        found_idx_r <= cmp_idx;
      end
      if (!rd_valid && !empty_r) begin
        empty_idx_r <= cmp_idx;
      end
      // strict compare keeps the lower index on equal stamps
      if ((cmp_idx == '0) || (rd_stamp < min_stamp_r)) begin
        min_stamp_r <= rd_stamp;
        min_idx_r   <= cmp_idx;
        min_page_r  <= rd_page;
      end
    end
  end

  // result register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r      <= found_r;
      out_frame_r    <= FRAME_W'(slot);
      out_ev_valid_r <= ev_valid;
      out_ev_page_r  <= ev_page;
      out_fault_r    <= faults_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame         = out_frame_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = out_fault_r;

endmodule

/* hdl/lrup_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrup_checker
// Port-level checks for the LRU page replacement core, bound to the top level.
// ----------------------------------------------------------------------------
module lrup_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit,
  input logic [lrup_pkg::FRAME_W-1:0]  out_frame,
  input logic                          out_evicted_valid,
  input logic [lrup_pkg::PAGE_W-1:0]   out_evicted_page,
  input logic [lrup_pkg::FAULT_W-1:0]  out_fault_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame) && $stable(out_hit)
      && $stable(out_fault_count))
    else $error("stalled result changed");

  // one request at a time: busy right after an accepted request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while a lookup is in flight");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid && (out_evicted_page == '0))
    else $error("eviction reported on a hit");

  // a miss has been counted
  a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_fault_count != '0))
    else $error("fault count zero on a miss");

endmodule

bind lru_page_replacement_core lrup_checker u_lrup_checker (.*);

/* bench/tb_lru_page_replacement_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement_core
// Self-checking bench for the LRU page replacement core. A queue of page
// requests feeds a clocked driver with random gaps. The result side is
// stalled at random. Each accepted request runs through a local LRU
// predictor, and the core's results are checked in order against it. Runs
// go through several frames_in_use settings, written only while idle.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_core;
  import lrup_pkg::*;

  localparam int NFR    = NUM_FRAMES_DEF;
  localparam int SETTLE = NFR + 6;

  // expected outcome of one page request
  typedef struct packed {
    logic                hit;
    logic [FRAME_W-1:0]  frame;
    logic                ev_valid;
    logic [PAGE_W-1:0]   ev_page;
    logic [FAULT_W-1:0]  faults;
  } lookup_res_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [PAGE_W-1:0]   in_page   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [FRAME_W-1:0]  out_frame;
  logic                out_evicted_valid;
  logic [PAGE_W-1:0]   out_evicted_page;
  logic [FAULT_W-1:0]  out_fault_count;

  lru_page_replacement_core #(
    .NUM_FRAMES(NFR)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame         (out_frame),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

  always #5 clk = ~clk;

  // pending page requests and expected lookup results
  logic [PAGE_W-1:0]  page_q[$];
  lookup_res_t        lookup_q[$];
  int                 err_cnt = 0;
  int                 res_cnt = 0;

  // predictor copy of the frame table
  logic [PAGE_W-1:0]  fr_page [NFR];
  bit                 fr_valid[NFR];
  logic [STAMP_W-1:0] fr_stamp[NFR];
  logic [STAMP_W-1:0] ref_cnt    = '0;
  logic [FAULT_W-1:0] fault_cnt  = '0;
  logic [CFG_W-1:0]   frames_cfg = CFG_RESET;

  // idling control
  bit                 in_taken     = 1'b0;
  int                 in_gap       = 0;
  int                 in_mode_left = 0;
  bit                 in_quiet     = 1'b0;
  int                 stall_left   = 0;
  int                 st_mode_left = 0;
  bit                 st_quiet     = 1'b0;

  // page pool for the random phases
  logic [PAGE_W-1:0]  pool[8];

  initial begin
    for (int i = 0; i < NFR; i++) begin
      fr_page[i]  = '0;
      fr_valid[i] = 1'b0;
      fr_stamp[i] = '0;
    end
  end

  // idle length: mostly short, now and then long
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("ERROR result %0d: %s", res_cnt, msg);
  endtask

  // LRU lookup on one request; updates the local table, queues the outcome
  task automatic predict_lookup(input logic [PAGE_W-1:0] pg);
    int                 n;
    int                 slot;
    bit                 found;
    bit                 empty;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] best;
    lookup_res_t        r;
    n = int'(frames_cfg);
    if (n == 0) n = 1;
    if (n > NFR) n = NFR;
    stamp = ref_cnt;
    if (ref_cnt != '1) ref_cnt = ref_cnt + 1'b1;
    slot  = 0;
    found = 1'b0;
    empty = 1'b0;
    r     = '0;
    // lowest matching frame wins, duplicates included
    for (int i = 0; i < n; i++) begin
      if (!found && fr_valid[i] && fr_page[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!empty && !fr_valid[i]) begin
          slot  = i;
          empty = 1'b1;
        end
      end
      // no empty frame: evict smallest stamp, lowest index on a tie
      if (!empty) begin
        best = fr_stamp[0];
        slot = 0;
        for (int i = 1; i < n; i++) begin
          if (fr_stamp[i] < best) begin
            best = fr_stamp[i];
            slot = i;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page  = fr_page[slot];
      end
      fr_page[slot]  = pg;
      fr_valid[slot] = 1'b1;
      if (fault_cnt != '1) fault_cnt = fault_cnt + 1'b1;
    end
    fr_stamp[slot] = stamp;
    r.frame  = slot[FRAME_W-1:0];
    r.faults = fault_cnt;
    lookup_q.push_back(r);
  endtask

  task automatic check_result();
    lookup_res_t e;
    if (lookup_q.size() == 0) begin
      report_mismatch("result with no request pending");
    end else begin
      e = lookup_q.pop_front();
      if (out_hit !== e.hit)
        report_mismatch($sformatf("hit %0d, want %0d", out_hit, e.hit));
      if (out_frame !== e.frame)
        report_mismatch($sformatf("frame %0d, want %0d", out_frame, e.frame));
      if (out_evicted_valid !== e.ev_valid)
        report_mismatch($sformatf("evicted_valid %0d, want %0d",
                                  out_evicted_valid, e.ev_valid));
      if (out_evicted_page !== e.ev_page)
        report_mismatch($sformatf("evicted_page 0x%04h, want 0x%04h",
                                  out_evicted_page, e.ev_page));
      if (out_fault_count !== e.faults)
        report_mismatch($sformatf("fault_count %0d, want %0d",
                                  out_fault_count, e.faults));
    end
    res_cnt++;
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_lookup(in_page);
    end
  end

  // request driver: holds a stalled request, else gap or next page
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (page_q.size() > 0) begin
        in_valid <= 1'b1;
        in_page  <= page_q.pop_front();
        if (in_mode_left == 0) begin
          in_quiet     = ($urandom_range(0, 3) == 0);
          in_mode_left = $urandom_range(20, 120);
        end else begin
          in_mode_left = in_mode_left - 1;
        end
        if (in_quiet || $urandom_range(0, 1) == 0) in_gap <= 0;
        else in_gap <= pick_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall generator
  always @(negedge clk) begin
    if (st_mode_left == 0) begin
      st_quiet     = ($urandom_range(0, 3) == 0);
      st_mode_left = $urandom_range(30, 300);
    end else begin
      st_mode_left = st_mode_left - 1;
    end
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!st_quiet && $urandom_range(0, 9) < 3) begin
      out_stall  <= 1'b1;
      stall_left <= pick_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // wait until every request is sent and answered, then let the core settle
  task automatic wait_idle();
    do @(posedge clk);
    while (page_q.size() != 0 || in_valid || lookup_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    frames_cfg  = v;
  endtask

  task automatic run_random(input logic [CFG_W-1:0] v, input int count);
    int psz;
    wait_idle();
    write_frames(v);
    // keep part of the old pool so left-out frames can hit again
    for (int i = 0; i < 8; i++)
      if ($urandom_range(0, 1) == 0) pool[i] = PAGE_W'($urandom());
    psz = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) page_q.push_back(pool[$urandom_range(0, psz - 1)]);
      else page_q.push_back(PAGE_W'($urandom()));
    end
  endtask

  // stimulus sequence
  initial begin
    logic [CFG_W-1:0] cfg_seq[12];
    cfg_seq = '{3'd1, 3'd4, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd1, 3'd5, 3'd6, 3'd4, 3'd2};
    for (int i = 0; i < 8; i++) pool[i] = PAGE_W'($urandom());
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: fill, hits, evictions of the oldest frame
    page_q.push_back(16'h0000);
    page_q.push_back(16'hFFFF);
    page_q.push_back(16'h1234);
    page_q.push_back(16'h0000);
    page_q.push_back(16'hFFFF);
    page_q.push_back(16'h5555);
    page_q.push_back(16'hAAAA);
    page_q.push_back(16'h5555);
    // one frame only
    wait_idle();
    write_frames(3'd1);
    page_q.push_back(16'h00FF);
    page_q.push_back(16'h00FF);
    // grow to all frames: left-out frames rejoin, empty frame gets filled
    wait_idle();
    write_frames(3'd4);
    page_q.push_back(16'h7E81);
    page_q.push_back(16'h8001);
    // shrink and bring the same page into frame 0 as well
    wait_idle();
    write_frames(3'd1);
    page_q.push_back(16'h8001);
    // duplicate residency: hit must take the lowest frame
    wait_idle();
    write_frames(3'd2);
    page_q.push_back(16'h8001);
    page_q.push_back(16'h5555);
    // zero frames acts as one
    wait_idle();
    write_frames(3'd0);
    page_q.push_back(16'h0000);
    page_q.push_back(16'h0000);
    // counts above the frame total are clipped
    wait_idle();
    write_frames(3'd7);
    page_q.push_back(16'h5555);
    page_q.push_back(16'h7E81);
    wait_idle();
    write_frames(3'd5);
    page_q.push_back(16'hFFFF);
    wait_idle();
    write_frames(3'd6);
    page_q.push_back(16'h0001);

    // random phases over the settings
    for (int p = 0; p < 12; p++) run_random(cfg_seq[p], 85);

    wait_idle();
    if (err_cnt == 0) begin
      $display("lru_page_replacement_core regression: pass");
    end else begin
      $display("lru_page_replacement_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd10_000_000);
    $display("lru_page_replacement_core regression: fail");
    $finish;
  end

endmodule
